@@ hw/rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL files.
// Each macro samples on i_clk and is off while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every sampled edge.
`define RGPT_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("rgpt assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define RGPT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rgpt assertion failed");

`endif

@@ hw/rtl/rgpt_pkg.sv @@
`default_nettype none

package rgpt_pkg;

    // Table size default
    localparam int RGPT_CAPACITY = 256;

    // Field widths
    localparam int ADDR_W     = 48;
    localparam int DBM_W      = 8;
    localparam int TIME_W     = 32;
    localparam int EXPIRY_W   = 16;
    localparam int COUNT_W    = 9;
    localparam int S_TDATA_W  = 88;
    localparam int M_TDATA_W  = 24;
    localparam int M_RES_W    = 21;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Register reset values
    localparam logic [DBM_W-1:0]    SIGNAL_GATE_RST = 8'hB5;  // -75 dBm
    localparam logic [EXPIRY_W-1:0] EXPIRY_RST      = 16'd300;

    // Register indexes (byte address / 4)
    localparam logic REG_SIGNAL_GATE    = 1'b0;
    localparam logic REG_EXPIRY_SECONDS = 1'b1;

    // Item kinds carried in tuser
    localparam logic ACT_REPORT = 1'b0;
    localparam logic ACT_PRUNE  = 1'b1;

    // Configuration seen by the core
    typedef struct packed {
        logic [DBM_W-1:0]    gate_dbm;
        logic [EXPIRY_W-1:0] expiry_seconds;
    } t_cfg;

    // One table entry as stored in memory
    typedef struct packed {
        logic              valid;
        logic [TIME_W-1:0] seen_at;
        logic [ADDR_W-1:0] address;
    } t_entry;

    // One result word, lowest field in the lowest bits
    typedef struct packed {
        logic [COUNT_W-1:0] active_count;
        logic [COUNT_W-1:0] removed_count;
        logic               dropped_full;
        logic               was_new;
        logic               passed_threshold;
    } t_result;

endpackage

`default_nettype wire

@@ hw/rtl/rgpt_cfg.sv @@
`default_nettype none

module rgpt_cfg
    import rgpt_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output t_cfg                       o_cfg
);

    logic [DBM_W-1:0]    r_gate_dbm;
    logic [EXPIRY_W-1:0] r_expiry_seconds;
    logic                w_wr;
    logic                w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    // word index; byte lanes below it are ignored
    assign w_idx  = paddr[2];

    // register writes in the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gate_dbm       <= SIGNAL_GATE_RST;
            r_expiry_seconds <= EXPIRY_RST;
        end else if (w_wr) begin
            case (w_idx)
                REG_SIGNAL_GATE:    r_gate_dbm       <= pwdata[DBM_W-1:0];
                REG_EXPIRY_SECONDS: r_expiry_seconds <= pwdata[EXPIRY_W-1:0];
                default: ;
            endcase
        end
    end

    // read mux; gate reads back sign-extended
    always_comb begin
        case (w_idx)
            REG_SIGNAL_GATE:
                prdata = {{(APB_DATA_W-DBM_W){r_gate_dbm[DBM_W-1]}}, r_gate_dbm};
            REG_EXPIRY_SECONDS:
                prdata = {{(APB_DATA_W-EXPIRY_W){1'b0}}, r_expiry_seconds};
            default:
                prdata = '0;
        endcase
    end

    assign o_cfg.gate_dbm       = r_gate_dbm;
    assign o_cfg.expiry_seconds = r_expiry_seconds;

endmodule

`default_nettype wire

@@ hw/rtl/rssi_gated_presence_table_top.sv @@
// Channel   Dir  Word                                                   Handshake
// s_axis    in   tdata: device_address, signal_dbm, now_seconds;       tvalid/tready
//                tuser: action (0 report, 1 prune)
// m_axis    out  tdata: passed_threshold, was_new, dropped_full,       tvalid/tready
//                removed_count, active_count
// apb       cfg  0x0 signal gate (dBm), 0x4 expiry_seconds              psel/penable
//
// One item at a time. A report at or below the gate goes from S_IDLE straight to S_FIN
// and its word is loaded into the output register from there. A tracked report or a
// prune reads one entry per cycle and compares the registered read word; a report that
// hits an entry ends the walk there, and otherwise the walk covers every entry.
// After reset a clearing pass over every entry zeroes the valid bits in memory;
// s_axis is not ready until it ends. A finished walk holds its word until the output
// register frees, and s_axis stays not ready meanwhile.
`default_nettype none
`include "assert_macros.svh"

module rssi_gated_presence_table_top
    import rgpt_pkg::*;
#(
    parameter int CAPACITY = RGPT_CAPACITY
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // s_axis
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // [47:0] device_address, [55:48] signal_dbm, [87:56] now_seconds
    input  wire logic [S_TDATA_W-1:0]  i_s_axis_tdata,
    // [0] action
    input  wire logic                  i_s_axis_tuser,
    // m_axis
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    // [0] passed_threshold, [1] was_new, [2] dropped_full,
    // [11:3] removed_count, [20:12] active_count, [23:21] zero
    output logic      [M_TDATA_W-1:0]  o_m_axis_tdata,
    // apb
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_CNT  = CW'(CAPACITY);
    localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_FIN
    } t_state;

    t_cfg                w_cfg;
    t_state              r_state;
    logic [CW-1:0]       r_idx;
    logic                r_rd_vld;
    logic [IW-1:0]       r_cmp_idx;
    logic                r_action;
    logic [ADDR_W-1:0]   r_addr;
    logic [TIME_W-1:0]   r_now;
    logic                r_free_found;
    logic [IW-1:0]       r_free_idx;
    logic [CW-1:0]       r_occ;
    logic [CW-1:0]       r_removed;
    t_result             r_res;
    t_result             r_out;
    logic                r_out_valid;

    // entry memory
    t_entry              r_mem [CAPACITY];
    t_entry              r_rdata;
    logic                w_we;
    logic [IW-1:0]       w_waddr;
    t_entry              w_wdata;

    // scan decode
    logic                w_in_acc;
    logic                w_passed;
    logic                w_cmp;
    logic                w_last;
    logic                w_match;
    logic                w_hit_now;
    logic                w_free_now;
    logic                w_any_free;
    logic [IW-1:0]       w_free_sel;
    logic [TIME_W-1:0]   w_age;
    logic                w_expire_now;
    logic                w_insert;
    logic                w_fin;
    logic                w_out_take;
    logic                w_load;
    logic [CW-1:0]       n_removed;
    logic [CW-1:0]       n_occ;
    t_result             n_res;

    rgpt_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // handshakes
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_take      = r_out_valid && i_m_axis_tready;
    assign w_load          = (r_state == S_FIN) && (!r_out_valid || i_m_axis_tready);
    assign w_passed        = $signed(i_s_axis_tdata[55:48]) > $signed(w_cfg.gate_dbm);

    // compare stage on the word read last cycle
    assign w_cmp        = (r_state == S_SCAN) && r_rd_vld;
    assign w_last       = (r_cmp_idx == LAST_IDX);
    assign w_match      = r_rdata.valid && (r_rdata.address == r_addr);
    assign w_hit_now    = w_cmp && (r_action == ACT_REPORT) && w_match;
    assign w_free_now   = w_cmp && !r_rdata.valid;
    assign w_any_free   = r_free_found || w_free_now;
    assign w_free_sel   = r_free_found ? r_free_idx : r_cmp_idx;
    assign w_age        = r_now - r_rdata.seen_at;
    assign w_expire_now = w_cmp && (r_action == ACT_PRUNE) && r_rdata.valid &&
                          (w_age > {{(TIME_W-EXPIRY_W){1'b0}}, w_cfg.expiry_seconds});
    assign w_insert     = w_cmp && w_last && (r_action == ACT_REPORT) && !w_hit_now &&
                          w_any_free;
    assign w_fin        = w_cmp && (w_last || w_hit_now);

    // write port: clear sweep, refresh on hit, insert at end, invalidate on expiry
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_cmp_idx;
        w_wdata = '{valid: 1'b1, seen_at: r_now, address: r_addr};
        case (r_state)
            S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_idx[IW-1:0];
                w_wdata = '0;
            end
            S_SCAN: begin
                if (w_hit_now) begin
                    w_we = 1'b1;
                end else if (w_expire_now) begin
                    w_we          = 1'b1;
                    w_wdata       = r_rdata;
                    w_wdata.valid = 1'b0;
                end else if (w_insert) begin
                    w_we    = 1'b1;
                    w_waddr = w_free_sel;
                end
            end
            default: ;
        endcase
    end

    // result of a finished walk
    always_comb begin
        n_removed = r_removed + CW'(w_expire_now);
        n_res     = '0;
        if (r_action == ACT_REPORT) begin
            n_res.passed_threshold = 1'b1;
            n_res.was_new          = !w_hit_now && w_any_free;
            n_res.dropped_full     = !w_hit_now && !w_any_free;
            n_occ                  = r_occ + CW'(n_res.was_new);
        end else begin
            n_res.removed_count = COUNT_W'(n_removed);
            n_occ               = r_occ - n_removed;
        end
        n_res.active_count = COUNT_W'(n_occ);
    end

    // memory: one write, one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[r_idx[IW-1:0]];
    end

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_idx        <= '0;
            r_rd_vld     <= 1'b0;
            r_occ        <= '0;
            r_out_valid  <= 1'b0;
            r_free_found <= 1'b0;
            r_removed    <= '0;
        end else begin
            // output word held until taken, reloaded from a finished item
            r_out_valid <= w_load || (r_out_valid && !w_out_take);
            case (r_state)
                S_CLEAR: begin
                    r_idx <= r_idx + 1'b1;
                    if (r_idx[IW-1:0] == LAST_IDX) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_action     <= i_s_axis_tuser;
                        r_addr       <= i_s_axis_tdata[ADDR_W-1:0];
                        r_now        <= i_s_axis_tdata[87:56];
                        r_idx        <= '0;
                        r_rd_vld     <= 1'b0;
                        r_free_found <= 1'b0;
                        r_removed    <= '0;
                        if ((i_s_axis_tuser == ACT_PRUNE) || w_passed) begin
                            r_state <= S_SCAN;
                        end else begin
                            r_res   <= '{active_count: COUNT_W'(r_occ), removed_count: '0,
                                         dropped_full: 1'b0, was_new: 1'b0,
                                         passed_threshold: 1'b0};
                            r_state <= S_FIN;
                        end
                    end
                end
                S_SCAN: begin
                    // issue the next read
                    if (r_idx < CAP_CNT) begin
                        r_idx     <= r_idx + 1'b1;
                        r_rd_vld  <= 1'b1;
                        r_cmp_idx <= r_idx[IW-1:0];
                    end else begin
                        r_rd_vld <= 1'b0;
                    end
                    // lowest free entry
                    if (w_free_now && !r_free_found) begin
                        r_free_found <= 1'b1;
                        r_free_idx   <= r_cmp_idx;
                    end
                    r_removed <= n_removed;
                    if (w_fin) begin
                        r_res   <= n_res;
                        r_occ   <= n_occ;
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (w_load) begin
                        r_out   <= r_res;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(M_TDATA_W-M_RES_W){1'b0}}, r_out};

    // checks
    `RGPT_ASSERT(a_occ_bound, r_occ <= CAP_CNT)
    `RGPT_ASSERT(a_no_write_idle, !((r_state == S_IDLE) && w_we))
    `RGPT_ASSERT(a_new_xor_drop, !(r_out_valid && r_out.was_new && r_out.dropped_full))
    `RGPT_ASSERT_NEXT(a_insert_grows, w_insert, r_occ == $past(r_occ) + 1'b1)

endmodule

`default_nettype wire

@@ tb/sv/rssi_gated_presence_table_top_tb.sv @@
`timescale 1ns / 1ps

module rssi_gated_presence_table_top_tb;
    import rgpt_pkg::*;

    localparam int CAPACITY    = RGPT_CAPACITY;
    localparam int QUIET_LIMIT = 5000;   // cycles with no handshake before giving up
    localparam int HOLD_CYCLES = 700;    // long receiver hold-off
    localparam int POOL_SIZE   = 320;    // more addresses than entries, so the table fills

    // Clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // DUT connections
    logic                  s_tvalid = 1'b0;
    logic                  s_ready;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;
    logic                  s_tuser  = ACT_REPORT;
    logic                  m_valid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_data;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    rssi_gated_presence_table_top #(
        .CAPACITY (CAPACITY)
    ) u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_ready),
        // [47:0] device_address, [55:48] signal_dbm, [87:56] now_seconds
        .i_s_axis_tdata  (s_tdata),
        // [0] action
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_tready),
        // [0] passed_threshold, [1] was_new, [2] dropped_full,
        // [11:3] removed_count, [20:12] active_count, [23:21] zero
        .o_m_axis_tdata  (m_data),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // Shadow copy of the presence table and its registers
    logic                     shadow_valid [CAPACITY];
    logic [ADDR_W-1:0]        shadow_addr  [CAPACITY];
    logic [TIME_W-1:0]        shadow_seen  [CAPACITY];
    int unsigned              shadow_occupied = 0;
    logic signed [DBM_W-1:0]  gate_dbm        = SIGNAL_GATE_RST;
    logic [EXPIRY_W-1:0]      expiry_s        = EXPIRY_RST;

    t_result           pending_results [$];
    int unsigned       mismatch_count = 0;
    int unsigned       quiet_cycles   = 0;
    logic [ADDR_W-1:0] addr_pool [POOL_SIZE];
    logic [TIME_W-1:0] clock_now = '0;
    int unsigned       burst_left = 0;
    bit                tx_gaps_on = 1'b1;
    bit                hold_req   = 1'b0;

    // Apply one item to the shadow table and return the word it should produce
    function automatic t_result presence_step(input logic act,
                                              input logic [ADDR_W-1:0] addr,
                                              input logic signed [DBM_W-1:0] dbm,
                                              input logic [TIME_W-1:0] now);
        t_result           res;
        bit                found;
        logic [TIME_W-1:0] age;
        int unsigned       removed;
        res     = '0;
        found   = 1'b0;
        removed = 0;
        if (act == ACT_REPORT) begin
            if (dbm > gate_dbm) begin
                res.passed_threshold = 1'b1;
                // refresh on a hit
                for (int i = 0; i < CAPACITY; i++) begin
                    if (!found && shadow_valid[i] && shadow_addr[i] == addr) begin
                        shadow_seen[i] = now;
                        found          = 1'b1;
                    end
                end
                if (!found) begin
                    // lowest free slot takes the new address
                    for (int i = 0; i < CAPACITY; i++) begin
                        if (!found && !shadow_valid[i]) begin
                            shadow_valid[i] = 1'b1;
                            shadow_addr[i]  = addr;
                            shadow_seen[i]  = now;
                            shadow_occupied++;
                            res.was_new     = 1'b1;
                            found           = 1'b1;
                        end
                    end
                    if (!found) res.dropped_full = 1'b1;
                end
            end
        end else begin
            // age wraps modulo 2^32
            for (int i = 0; i < CAPACITY; i++) begin
                if (shadow_valid[i]) begin
                    age = now - shadow_seen[i];
                    if (age > TIME_W'(expiry_s)) begin
                        shadow_valid[i] = 1'b0;
                        removed++;
                    end
                end
            end
            shadow_occupied -= removed;
        end
        res.removed_count = COUNT_W'(removed);
        res.active_count  = COUNT_W'(shadow_occupied);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        if (mismatch_count < 40)
            $display("MISMATCH @%0t: %s got %0d expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    // Send one input word; sender runs in bursts with random gaps between them
    task automatic send_word(input logic act, input logic [ADDR_W-1:0] addr,
                             input int dbm, input logic [TIME_W-1:0] now);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 3) == 0 || !tx_gaps_on) ? 0 : $urandom_range(1, 30);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {now, DBM_W'(dbm), addr};
        @(posedge clk);
        while (!s_ready) @(posedge clk);
        pending_results.push_back(presence_step(act, addr, DBM_W'(dbm), now));
        burst_left--;
        @(negedge clk);
    endtask

    // Stop offering words and wait until every expected word has come back
    task automatic drain_block();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    // APB write: setup then access; shadow register follows the write
    task automatic cfg_write(input logic idx, input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        case (idx)
            REG_SIGNAL_GATE:    gate_dbm = value[DBM_W-1:0];
            REG_EXPIRY_SECONDS: expiry_s = value[EXPIRY_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Gate edges, hit/miss, expiry boundary and time wrap at reset settings
    task automatic test_directed();
        send_word(ACT_REPORT, 48'h0, 127, 32'd0);                   // new
        send_word(ACT_REPORT, 48'hFFFF_FFFF_FFFF, -74, 32'd0);      // just above the gate
        send_word(ACT_REPORT, 48'h1234_5678_9ABC, -75, 32'd50);     // equal to gate, not tracked
        send_word(ACT_REPORT, 48'h5A5A_5A5A_5A5A, -128, 32'd50);    // far below gate
        send_word(ACT_REPORT, 48'h0, 0, 32'd100);                   // hit, refresh
        send_word(ACT_PRUNE, 48'hDEAD_BEEF_0123, -5, 32'd300);      // age equals expiry, kept
        send_word(ACT_PRUNE, 48'h0, 0, 32'd301);                    // one past expiry
        send_word(ACT_REPORT, 48'hA5A5_A5A5_A5A5, 127, 32'hFFFF_FFFF);
        send_word(ACT_PRUNE, 48'h0, 0, 32'd0);                      // wrap: age 1 kept
        send_word(ACT_REPORT, 48'h0000_0000_0001, 1, 32'd1000);
        send_word(ACT_PRUNE, 48'h0, 0, 32'd999);                    // last-seen in the future
        send_word(ACT_REPORT, 48'h0, 127, 32'h8000_0000);
        send_word(ACT_PRUNE, 48'hFFFF_FFFF_FFFF, -128, 32'h8000_0000);
        send_word(ACT_REPORT, 48'h0, 127, 32'h8000_0000);           // hit, same time
        drain_block();
    endtask

    // Register extremes: gate at both ends, expiry of zero and the maximum
    task automatic test_config_extremes();
        cfg_write(REG_SIGNAL_GATE, 32'(127));
        send_word(ACT_REPORT, 48'h0F0F_0F0F_0F0F, 127, 32'd10);     // nothing passes
        send_word(ACT_REPORT, 48'h0F0F_0F0F_0F0F, -128, 32'd10);
        drain_block();
        cfg_write(REG_SIGNAL_GATE, 32'(-128));
        cfg_write(REG_EXPIRY_SECONDS, 32'd0);
        send_word(ACT_REPORT, 48'h3C3C_3C3C_3C3C, -128, 32'd5);     // equal to gate
        send_word(ACT_REPORT, 48'h3C3C_3C3C_3C3C, -127, 32'd5);
        send_word(ACT_PRUNE, 48'h0, 0, 32'd5);                      // age zero survives
        send_word(ACT_PRUNE, 48'h0, 0, 32'd6);                      // any nonzero age goes
        drain_block();
        cfg_write(REG_EXPIRY_SECONDS, 32'd65535);
        send_word(ACT_REPORT, 48'hC3C3_C3C3_C3C3, 64, 32'd10);
        send_word(ACT_PRUNE, 48'h0, 0, 32'd65545);                  // age at the maximum, kept
        send_word(ACT_PRUNE, 48'h0, 0, 32'd65546);
        drain_block();
    endtask

    // Empty the table, fill every entry, overflow it, then age everything out
    task automatic test_table_full();
        logic [TIME_W-1:0] base;
        logic [ADDR_W-1:0] first_addr;
        logic [ADDR_W-1:0] addr;
        base = 32'd5000;
        cfg_write(REG_EXPIRY_SECONDS, 32'd0);
        send_word(ACT_PRUNE, 48'h0, 0, base);
        send_word(ACT_PRUNE, 48'h0, 0, base + 1);
        drain_block();
        cfg_write(REG_EXPIRY_SECONDS, 32'd65535);
        cfg_write(REG_SIGNAL_GATE, 32'(-128));
        first_addr = '0;
        for (int i = 0; i < CAPACITY + 4; i++) begin
            addr = {32'($urandom), 7'd0, 9'(i)};
            if (i == 0) first_addr = addr;
            send_word(ACT_REPORT, addr, $urandom_range(0, 127) - 127 + 127, base + i);
        end
        send_word(ACT_REPORT, first_addr, -1, base + 400);          // hit while full
        send_word(ACT_REPORT, 48'hFFFF_0000_FFFF, -128, base + 400);
        send_word(ACT_PRUNE, 48'h0, 0, base + 400 + 65536);         // removes all entries
        drain_block();
    endtask

    // Receiver holds off while the sender keeps offering, so the input stalls
    task automatic test_backpressure();
        drain_block();
        cfg_write(REG_SIGNAL_GATE, 32'(-75));
        tx_gaps_on = 1'b0;
        hold_req   = 1'b1;
        for (int i = 0; i < 12; i++) begin
            clock_now += 1;
            send_word(i % 4 == 3 ? ACT_PRUNE : ACT_REPORT,
                      addr_pool[$urandom_range(0, POOL_SIZE - 1)], 100, clock_now);
        end
        tx_gaps_on = 1'b1;
        drain_block();
    endtask

    // Random traffic under one register setting
    task automatic test_random_traffic(input int th, input int unsigned exp_s,
                                       input int unsigned prune_pct,
                                       input int unsigned fresh_pct,
                                       input int unsigned step_max, input int unsigned n);
        logic              act;
        logic [ADDR_W-1:0] addr;
        int                dbm;
        int unsigned       pick;
        drain_block();
        cfg_write(REG_SIGNAL_GATE, 32'(th));
        cfg_write(REG_EXPIRY_SECONDS, 32'(exp_s));
        for (int k = 0; k < n; k++) begin
            act  = ($urandom_range(0, 99) < prune_pct) ? ACT_PRUNE : ACT_REPORT;
            pick = $urandom_range(0, 99);
            if (pick < fresh_pct)
                addr = {16'($urandom), 32'($urandom)};
            else if (pick < fresh_pct + (100 - fresh_pct) / 2)
                addr = addr_pool[$urandom_range(0, 39)];
            else
                addr = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
            if ($urandom_range(0, 99) < 75 && th < 127)
                dbm = th + 1 + int'($urandom_range(0, 126 - th));
            else
                dbm = int'($urandom_range(0, 255)) - 128;
            // mostly forward time, rare jumps anywhere (entries then look future-dated)
            if ($urandom_range(0, 49) == 0)
                clock_now = $urandom;
            else if (act == ACT_PRUNE && $urandom_range(0, 2) == 0)
                clock_now += $urandom_range(0, 2 * exp_s);
            else
                clock_now += $urandom_range(0, step_max);
            send_word(act, addr, dbm, clock_now);
        end
    endtask

    // Receiver stall pattern, plus the long hold-off on request
    initial begin : rx_pattern
        int unsigned mode;
        int unsigned left;
        int unsigned stall_left;
        mode       = 0;
        left       = 0;
        stall_left = 0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end else begin
                if (left == 0) begin
                    mode = $urandom_range(0, 2);
                    left = $urandom_range(20, 300);
                end
                left--;
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 2) != 0);
                    default: begin
                        if (stall_left != 0) begin
                            stall_left--;
                            m_tready <= 1'b0;
                        end else if ($urandom_range(0, 9) == 0) begin
                            stall_left = $urandom_range(5, 40);
                            m_tready <= 1'b0;
                        end else begin
                            m_tready <= 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    // Compare each result word with the oldest expectation
    always @(posedge clk) begin : result_check
        t_result got_w;
        t_result want_w;
        if (rst_n && m_valid && m_tready) begin
            got_w = t_result'(m_data[M_RES_W-1:0]);
            if (pending_results.size() == 0) begin
                report_mismatch("word with nothing expected, active_count",
                                got_w.active_count, 0);
            end else begin
                want_w = pending_results.pop_front();
                if (got_w.passed_threshold != want_w.passed_threshold)
                    report_mismatch("passed_threshold", got_w.passed_threshold,
                                    want_w.passed_threshold);
                if (got_w.was_new != want_w.was_new)
                    report_mismatch("was_new", got_w.was_new, want_w.was_new);
                if (got_w.dropped_full != want_w.dropped_full)
                    report_mismatch("dropped_full", got_w.dropped_full, want_w.dropped_full);
                if (got_w.removed_count != want_w.removed_count)
                    report_mismatch("removed_count", got_w.removed_count,
                                    want_w.removed_count);
                if (got_w.active_count != want_w.active_count)
                    report_mismatch("active_count", got_w.active_count, want_w.active_count);
                if (m_data[M_TDATA_W-1:M_RES_W] != '0)
                    report_mismatch("tdata pad bits", m_data[M_TDATA_W-1:M_RES_W], 0);
            end
        end
    end

    // Watchdog: stop when no word moves on either side for too long
    always @(posedge clk) begin
        if ((s_tvalid && s_ready) || (m_valid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < CAPACITY; i++) begin
            shadow_valid[i] = 1'b0;
            shadow_addr[i]  = '0;
            shadow_seen[i]  = '0;
        end
        for (int i = 0; i < POOL_SIZE; i++)
            addr_pool[i] = {16'($urandom), 32'($urandom)};

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed();
        test_config_extremes();
        test_table_full();
        clock_now = 32'd100;
        test_random_traffic(-75, 300, 12, 15, 40, 210);
        test_random_traffic(-128, 65535, 2, 60, 4, 210);
        test_backpressure();
        test_random_traffic(-90, 65535, 2, 60, 4, 210);
        clock_now = 32'hFFFF_FF80;
        test_random_traffic(-100, 1, 20, 15, 3, 210);
        begin : last_phase
            int unsigned e;
            e = $urandom_range(1, 65535);
            test_random_traffic(int'($urandom_range(0, 168)) - 128, e, 10, 20, e / 16 + 1, 210);
        end

        drain_block();
        repeat (CAPACITY + 8) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
